>>> hdl/etc1_pkg.sv
package etc1_pkg;

	localparam int unsigned BlockW = 64;
	localparam int unsigned PixCntW = 4;
	localparam logic [PixCntW-1:0] LastPix = 4'd15;
	localparam int unsigned ChanW = 8;
	localparam int unsigned SumW = 10;
	localparam int unsigned ModW = 9;

	typedef logic [ChanW-1:0] chan_t;
	typedef logic signed [SumW-1:0] sum_t;
	typedef logic signed [ModW-1:0] mod_t;

	typedef enum logic {
		ORDER_RGB = 1'b0,
		ORDER_BGR = 1'b1
	} chan_order_t;

	// one pixel request from the sequencer into the pixel pipeline
	typedef struct packed {
		logic              valid;
		logic [BlockW-1:0] block;
		logic [PixCntW-1:0] pix;
	} pix_req_t;

	// modifier table, indexed by table codeword and the two index bits
	function automatic mod_t mod_val(input logic [2:0] tsel, input logic [1:0] idx);
		mod_t mag_lo;
		mod_t mag_hi;
		mod_t mag;
		unique case (tsel)
			3'd0: begin mag_lo = 9'sd2;  mag_hi = 9'sd8;   end
			3'd1: begin mag_lo = 9'sd5;  mag_hi = 9'sd17;  end
			3'd2: begin mag_lo = 9'sd9;  mag_hi = 9'sd29;  end
			3'd3: begin mag_lo = 9'sd13; mag_hi = 9'sd42;  end
			3'd4: begin mag_lo = 9'sd18; mag_hi = 9'sd60;  end
			3'd5: begin mag_lo = 9'sd24; mag_hi = 9'sd80;  end
			3'd6: begin mag_lo = 9'sd33; mag_hi = 9'sd106; end
			default: begin mag_lo = 9'sd47; mag_hi = 9'sd183; end
		endcase
		mag = idx[0] ? mag_hi : mag_lo;
		return idx[1] ? -mag : mag;
	endfunction

	function automatic chan_t exp5(input logic [4:0] v);
		return {v, v[4:2]};
	endfunction

	function automatic chan_t exp4(input logic [3:0] v);
		return {v, v};
	endfunction

	function automatic chan_t clamp8(input sum_t v);
		if (v < 0) begin
			return '0;
		end else if (v > sum_t'(255)) begin
			return '1;
		end
		return v[ChanW-1:0];
	endfunction

endpackage

>>> hdl/etc1_issue.sv
module etc1_issue
	import etc1_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [BlockW-1:0] block_word,
	output logic              busy,
	output pix_req_t          req
);

	logic [BlockW-1:0]  block_q;
	logic [PixCntW-1:0] cnt_q;
	logic               active_q;
	logic               take;

	// free on the final pixel beat so the next block follows without a gap
	assign busy = active_q && (cnt_q != LastPix);
	assign take = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			cnt_q    <= '0;
		end else if (take) begin
			active_q <= 1'b1;
			cnt_q    <= '0;
		end else if (active_q) begin
			active_q <= (cnt_q != LastPix);
			cnt_q    <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			block_q <= block_word;
		end
	end

	assign req.valid = active_q;
	assign req.block = block_q;
	assign req.pix   = cnt_q;

	a_take_starts: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> active_q && cnt_q == '0)
		else $error("accepted block did not start at pixel zero");

	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		active_q && cnt_q != LastPix |=> active_q && cnt_q == $past(cnt_q) + 1'b1)
		else $error("pixel sequence skipped or stalled");

	a_end: assert property (@(posedge clk) disable iff (!arst_n)
		active_q && cnt_q == LastPix && !start |=> !active_q)
		else $error("sequencer ran past the last pixel");

endmodule

>>> hdl/etc1_pix.sv
module etc1_pix
	import etc1_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  pix_req_t req,
	input  logic     order,
	output logic     strobe,
	output logic [1:0] pos_x,
	output logic [1:0] pos_y,
	output chan_t    chan_first,
	output chan_t    chan_mid,
	output chan_t    chan_last,
	output logic     last_pixel
);

	// stage 1: subblock select, base colour decode, index bits
	logic [31:0] hi;
	logic [31:0] lo;
	logic [1:0]  px;
	logic [1:0]  py;
	logic        sb;
	logic [3:0]  k;
	chan_t       base_c [3];
	logic [2:0]  tsel_c;
	logic [1:0]  idx_c;

	always_comb begin
		logic [4:0] b5;
		logic [2:0] d3;
		logic [4:0] b5d;
		hi = req.block[63:32];
		lo = req.block[31:0];
		px = req.pix[1:0];
		py = req.pix[3:2];
		sb = hi[0] ? py[1] : px[1];
		k  = {px, py};
		for (int c = 0; c < 3; c++) begin
			b5  = hi[31-8*c -: 5];
			d3  = hi[26-8*c -: 3];
			b5d = b5 + {{2{d3[2]}}, d3};
			if (hi[1]) begin
				base_c[c] = sb ? exp5(b5d) : exp5(b5);
			end else begin
				base_c[c] = sb ? exp4(hi[27-8*c -: 4]) : exp4(hi[31-8*c -: 4]);
			end
		end
		tsel_c = sb ? hi[4:2] : hi[7:5];
		idx_c  = {lo[5'(k) + 5'd16], lo[k]};
	end

	logic       valid_s1;
	chan_t      base_s1 [3];
	logic [2:0] tsel_s1;
	logic [1:0] idx_s1;
	logic [1:0] x_s1;
	logic [1:0] y_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		base_s1 <= base_c;
		tsel_s1 <= tsel_c;
		idx_s1  <= idx_c;
		x_s1    <= px;
		y_s1    <= py;
	end

	// stage 2: modifier lookup and add
	logic  valid_s2;
	sum_t  sum_s2 [3];
	logic [1:0] x_s2;
	logic [1:0] y_s2;
	mod_t  mod_c;

	assign mod_c = mod_val(tsel_s1, idx_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		for (int c = 0; c < 3; c++) begin
			sum_s2[c] <= sum_t'({2'b00, base_s1[c]}) + sum_t'(mod_c);
		end
		x_s2 <= x_s1;
		y_s2 <= y_s1;
	end

	// stage 3: clamp and channel order
	logic  valid_s3;
	chan_t first_s3;
	chan_t mid_s3;
	chan_t last_s3;
	logic [1:0] x_s3;
	logic [1:0] y_s3;
	chan_t r_c;
	chan_t g_c;
	chan_t b_c;

	assign r_c = clamp8(sum_s2[0]);
	assign g_c = clamp8(sum_s2[1]);
	assign b_c = clamp8(sum_s2[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		first_s3 <= (order == ORDER_BGR) ? b_c : r_c;
		mid_s3   <= g_c;
		last_s3  <= (order == ORDER_BGR) ? r_c : b_c;
		x_s3     <= x_s2;
		y_s3     <= y_s2;
	end

	assign strobe     = valid_s3;
	assign pos_x      = x_s3;
	assign pos_y      = y_s3;
	assign chan_first = first_s3;
	assign chan_mid   = mid_s3;
	assign chan_last  = last_s3;
	assign last_pixel = (x_s3 == 2'd3) && (y_s3 == 2'd3);

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(req.valid, 3))
		else $error("pixel beat without matching request");

	a_dense: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last_pixel |=> strobe)
		else $error("gap inside a block's pixel beats");

	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && $past(strobe) && !$past(last_pixel) |->
			{pos_y, pos_x} == $past({pos_y, pos_x}) + 4'd1)
		else $error("pixels out of raster order");

endmodule

>>> hdl/etc1_block_decode_top.sv
// ETC1 block decoder.
// Input: pulse start with block_word (first stored byte in bits 63..56);
// the block is taken at a clock edge where start is high and busy is low.
// Output: sixteen pixel beats in raster order, one per cycle, each marked
// by strobe for a single cycle, with pos_x/pos_y and three 8-bit channels;
// last_pixel flags the sixteenth. The receiver cannot hold beats off.
// The accepting edge loads the sequencer; the first pixel's strobe follows
// through valid_s1, valid_s2 and valid_s3. Block rate is set by the
// one-pixel-per-cycle output; busy drops during the last pixel issue cycle
// so a new block follows with no gap. Pixels run through a three-stage pipeline
// (decode, modifier add, clamp) behind the pixel sequencer.
// Config: cfg_valid/cfg_ready/cfg_data writes channel_order (bit 0):
// 0 gives R,G,B, 1 gives B,G,R. Write only while no block is in flight.
// Reset: asynchronous, active low; clears the sequencer, the pipeline
// valid bits and channel_order.
module etc1_block_decode_top
	import etc1_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [BlockW-1:0] block_word,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic              cfg_data,
	output logic              strobe,
	output logic [1:0]        pos_x,
	output logic [1:0]        pos_y,
	output logic [7:0]        chan_first,
	output logic [7:0]        chan_mid,
	output logic [7:0]        chan_last,
	output logic              last_pixel
);

	logic     order_q;
	pix_req_t req;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q <= ORDER_RGB;
		end else if (cfg_valid && cfg_ready) begin
			order_q <= cfg_data;
		end
	end

	etc1_issue u_issue (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.block_word (block_word),
		.busy       (busy),
		.req        (req)
	);

	etc1_pix u_pix (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.order      (order_q),
		.strobe     (strobe),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.chan_first (chan_first),
		.chan_mid   (chan_mid),
		.chan_last  (chan_last),
		.last_pixel (last_pixel)
	);

endmodule

>>> test/etc1_block_decode_chk.sv
module etc1_block_decode_chk
	import etc1_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              busy,
	input  logic [BlockW-1:0] block_word,
	input  logic              cfg_valid,
	input  logic              cfg_ready,
	input  logic              cfg_data,
	input  logic              strobe,
	input  logic [1:0]        pos_x,
	input  logic [1:0]        pos_y,
	input  logic [7:0]        chan_first,
	input  logic [7:0]        chan_mid,
	input  logic [7:0]        chan_last,
	input  logic              last_pixel,
	output int                fail_cnt,
	output int                pending_cnt
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [1:0] px;
		logic [1:0] py;
		logic [7:0] ch_first;
		logic [7:0] ch_mid;
		logic [7:0] ch_last;
		logic       is_last;
	} pixel_t;

	chan_order_t order_q = ORDER_RGB;
	pixel_t      pixel_q[$];

	function automatic int mod_mag(input logic [2:0] tsel, input logic big);
		case (tsel)
			3'd0: return big ? 8 : 2;
			3'd1: return big ? 17 : 5;
			3'd2: return big ? 29 : 9;
			3'd3: return big ? 42 : 13;
			3'd4: return big ? 60 : 18;
			3'd5: return big ? 80 : 24;
			3'd6: return big ? 106 : 33;
			default: return big ? 183 : 47;
		endcase
	endfunction

	function automatic logic [7:0] sat_u8(input int v);
		if (v < 0) begin
			return 8'd0;
		end else if (v > 255) begin
			return 8'd255;
		end
		return v[7:0];
	endfunction

	// 5-bit base plus signed 3-bit delta, wrapping mod 32
	function automatic logic [4:0] add_delta(input logic [4:0] b5, input logic [2:0] d3);
		return b5 + {{2{d3[2]}}, d3};
	endfunction

	function automatic void note(input string msg);
		fail_cnt++;
		if (fail_cnt <= 10) begin
			$display("%0t ns: %s", $realtime, msg);
		end
	endfunction

	// expand one block into its sixteen pixels, raster order
	function automatic void decode_block(input logic [BlockW-1:0] blk);
		logic [7:0] base [2][3];
		logic [2:0] tsel [2];
		logic [4:0] b5;
		logic [1:0] idx;
		logic [7:0] r, g, b;
		int         sb, k, mod, n;
		pixel_t     p;
		for (int ch = 0; ch < 3; ch++) begin
			if (blk[33]) begin
				b5 = blk[63-8*ch -: 5];
				base[0][ch] = {b5, b5[4:2]};
				b5 = add_delta(b5, blk[58-8*ch -: 3]);
				base[1][ch] = {b5, b5[4:2]};
			end else begin
				base[0][ch] = {2{blk[63-8*ch -: 4]}};
				base[1][ch] = {2{blk[59-8*ch -: 4]}};
			end
		end
		tsel[0] = blk[39:37];
		tsel[1] = blk[36:34];
		n = 0;
		for (int y = 0; y < 4; y++) begin
			for (int x = 0; x < 4; x++) begin
				sb = blk[32] ? y / 2 : x / 2;
				k = y + 4 * x;
				idx = {blk[16+k], blk[k]};
				mod = mod_mag(tsel[sb], idx[0]);
				if (idx[1]) begin
					mod = -mod;
				end
				r = sat_u8(int'(base[sb][0]) + mod);
				g = sat_u8(int'(base[sb][1]) + mod);
				b = sat_u8(int'(base[sb][2]) + mod);
				p.px = 2'(x);
				p.py = 2'(y);
				p.ch_first = (order_q == ORDER_BGR) ? b : r;
				p.ch_mid = g;
				p.ch_last = (order_q == ORDER_BGR) ? r : b;
				p.is_last = (n == 15);
				pixel_q.push_back(p);
				n++;
			end
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		pixel_t want;
		pixel_t got;
		if (!arst_n) begin
			order_q = ORDER_RGB;
			pixel_q.delete();
			pending_cnt = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				order_q = chan_order_t'(cfg_data);
			end
			if (strobe) begin
				got = {pos_x, pos_y, chan_first, chan_mid, chan_last, last_pixel};
				if (pixel_q.size() == 0) begin
					note($sformatf("unexpected pixel x%0d y%0d %02h %02h %02h last %0b",
						got.px, got.py, got.ch_first, got.ch_mid, got.ch_last, got.is_last));
				end else begin
					want = pixel_q.pop_front();
					if (got !== want) begin
						note($sformatf({"pixel mismatch: got x%0d y%0d %02h %02h %02h last %0b,",
							" want x%0d y%0d %02h %02h %02h last %0b"},
							got.px, got.py, got.ch_first, got.ch_mid, got.ch_last, got.is_last,
							want.px, want.py, want.ch_first, want.ch_mid, want.ch_last,
							want.is_last));
					end
				end
			end
			if (start && !busy) begin
				decode_block(block_word);
			end
			pending_cnt = pixel_q.size();
		end
	end

endmodule

>>> test/tb_etc1_block_decode_top.sv
module tb_etc1_block_decode_top
	import etc1_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic              busy;
	logic [BlockW-1:0] block_word = '0;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic              cfg_data = 1'b0;
	logic              strobe;
	logic [1:0]        pos_x;
	logic [1:0]        pos_y;
	logic [7:0]        chan_first;
	logic [7:0]        chan_mid;
	logic [7:0]        chan_last;
	logic              last_pixel;
	int                fail_cnt;
	int                pending_cnt;
	int                burst = 0;

	etc1_block_decode_top u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.block_word (block_word),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.strobe     (strobe),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.chan_first (chan_first),
		.chan_mid   (chan_mid),
		.chan_last  (chan_last),
		.last_pixel (last_pixel)
	);

	etc1_block_decode_chk u_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.block_word  (block_word),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.strobe      (strobe),
		.pos_x       (pos_x),
		.pos_y       (pos_y),
		.chan_first  (chan_first),
		.chan_mid    (chan_mid),
		.chan_last   (chan_last),
		.last_pixel  (last_pixel),
		.fail_cnt    (fail_cnt),
		.pending_cnt (pending_cnt)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("Test completed with failures");
		$finish;
	end

	function automatic logic [BlockW-1:0] etc_blk(input logic [23:0] colors,
		input logic [2:0] t1, input logic [2:0] t2, input logic diff, input logic flip,
		input logic [31:0] idx);
		return {colors, t1, t2, diff, flip, idx};
	endfunction

	// mostly raw bits; some blocks get extreme bases to push the clamps
	function automatic logic [BlockW-1:0] rand_blk();
		logic [BlockW-1:0] blk;
		blk = {$urandom, $urandom};
		case ($urandom_range(0, 4))
			0: blk[63:40] = '1;
			1: blk[63:40] = '0;
			default: ;
		endcase
		return blk;
	endfunction

	function automatic int draw_gap();
		if (burst > 0) begin
			burst--;
			return 0;
		end else if ($urandom_range(0, 7) == 0) begin
			burst = $urandom_range(4, 12);
			return 0;
		end
		return $urandom_range(0, 19);
	endfunction

	// call at a falling edge; returns at the falling edge after the beat
	task automatic push_block(input logic [BlockW-1:0] blk);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		block_word <= blk;
		do @(posedge clk); while (busy);
		@(negedge clk);
	endtask

	task automatic write_order(input chan_order_t order);
		cfg_valid <= 1'b1;
		cfg_data <= order;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// drop start, wait for the last pixel, then let the pipeline settle
	task automatic drain();
		start <= 1'b0;
		while (pending_cnt != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	initial begin
		logic [BlockW-1:0] directed_q[$];
		chan_order_t order;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		directed_q.push_back('0);
		directed_q.push_back('1);
		// saturate high and low in individual mode
		directed_q.push_back(etc_blk(24'hFFFFFF, 3'd7, 3'd7, 1'b0, 1'b0, 32'h0000_FFFF));
		directed_q.push_back(etc_blk(24'h000000, 3'd7, 3'd7, 1'b0, 1'b1, 32'hFFFF_FFFF));
		// differential: 31 + 3 wraps up, 0 - 4 wraps down, then a mix
		directed_q.push_back(etc_blk(24'hFBFBFB, 3'd0, 3'd1, 1'b1, 1'b0, 32'h5555_AAAA));
		directed_q.push_back(etc_blk(24'h040404, 3'd2, 3'd3, 1'b1, 1'b1, 32'hAAAA_5555));
		directed_q.push_back(etc_blk(24'h870DF3, 3'd4, 3'd5, 1'b1, 1'b0, 32'h0F0F_F0F0));
		directed_q.push_back(etc_blk(24'h1E2D3C, 3'd6, 3'd7, 1'b0, 1'b1, 32'h3333_CCCC));
		for (int t = 0; t < 8; t++) begin
			directed_q.push_back(etc_blk(24'($urandom), 3'(t), 3'(7 - t), t[0], t[1], $urandom));
		end

		write_order(ORDER_RGB);
		foreach (directed_q[i]) begin
			push_block(directed_q[i]);
		end
		drain();

		for (int ph = 1; ph <= 4; ph++) begin
			order = (ph == 4) ? chan_order_t'($urandom_range(0, 1)) : chan_order_t'(ph[0]);
			write_order(order);
			for (int i = 0; i < 26; i++) begin
				push_block(rand_blk());
			end
			drain();
		end

		if (fail_cnt == 0 && pending_cnt == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
